FILE: hdl/dllm_pkg.sv
// shared types and constants of the doubly linked list manager
package dllm_pkg;

  localparam int unsigned NODES_DEF      = 16;
  localparam int unsigned ITEM_WIDTH_DEF = 32;

  // fixed stream field widths
  localparam int unsigned OP_W     = 3;
  localparam int unsigned ITEM_W   = 32;
  localparam int unsigned NODE_W   = 4;
  localparam int unsigned HANDLE_W = 4;
  localparam int unsigned SIZE_W   = 5;
  localparam int unsigned S_DATA_W = 40;
  localparam int unsigned M_DATA_W = 48;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5,
    OP_INSERT     = 3'd6,
    OP_UNLINK     = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WR2,
    S_DONE
  } state_e;

endpackage

FILE: hdl/doubly_linked_list_manager_top.sv
// doubly linked list manager: node pool in synchronous memories with a sequencer
//
//  channel  dir  handshake                      payload
//  s_axis   in   s_axis_tvalid / s_axis_tready  tdata: item, node; tuser: operation
//  m_axis   out  m_axis_tvalid / m_axis_tready  tdata: item_out, new_handle, ok, size, empty_res
//
// each operation runs in order: the transfer cycle issues the link and item reads,
// the next cycle (S_EXEC) applies the first memory writes, S_WR2 applies the second writes
// (the write port of each link memory takes one entry a cycle) and loads the output register.
// a stalled output holds the sequencer until the result register is free.
// reset clears the state, pointers, counters and valid flags only; nodes never allocated
// are tracked by a fill count, so no clearing pass runs after reset.
module doubly_linked_list_manager_top #(
  parameter int unsigned NODES      = dllm_pkg::NODES_DEF,
  parameter int unsigned ITEM_WIDTH = dllm_pkg::ITEM_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [31:0] item, [35:32] node, [39:36] zero
  input  logic [dllm_pkg::S_DATA_W-1:0] s_axis_tdata,
  // [2:0] operation
  input  logic [dllm_pkg::OP_W-1:0]     s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [31:0] item_out, [35:32] new_handle, [36] ok, [41:37] size, [42] empty_res,
  // [47:43] zero
  output logic [dllm_pkg::M_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned HW = $clog2(NODES);
  localparam int unsigned LW = $clog2(NODES + 1);
  localparam int unsigned NW = (LW > dllm_pkg::NODE_W) ? LW : dllm_pkg::NODE_W;
  localparam logic [LW-1:0] NIL = LW'(NODES);

  // node pool memories
  logic [ITEM_WIDTH-1:0] item_mem [NODES];
  logic [LW-1:0]         next_mem [NODES];
  logic [LW-1:0]         prev_mem [NODES];
  logic                  use_mem  [NODES];

  dllm_pkg::state_e state_q, state_d;
  dllm_pkg::op_e    op_q, in_op;

  logic [ITEM_WIDTH-1:0] item_q;
  logic [LW-1:0]         tgt_q, tgt_in;
  logic                  fresh_a_q, fresh_b_q;

  logic [LW-1:0]         nxa_q, nxb_q, pv_q;
  logic                  us_q;
  logic [ITEM_WIDTH-1:0] it_q;

  logic [LW-1:0] head_q, head_d, tail_q, tail_d, free_q, free_d;
  logic [LW-1:0] cnt_q, cnt_d, fill_q, fill_d;

  logic          w2_nx_en_q, w2_nx_en_d, w2_pv_en_q, w2_pv_en_d;
  logic [HW-1:0] w2_nx_addr_q, w2_nx_addr_d, w2_pv_addr_q, w2_pv_addr_d;
  logic [LW-1:0] w2_nx_data_q, w2_nx_data_d, w2_pv_data_q, w2_pv_data_d;

  logic [dllm_pkg::ITEM_W-1:0]   res_item_q, res_item_d;
  logic [dllm_pkg::HANDLE_W-1:0] res_handle_q, res_handle_d;
  logic                          res_ok_q, res_ok_d, res_empty_q, res_empty_d;
  logic [dllm_pkg::SIZE_W-1:0]   res_size_q, res_size_d;

  logic                          m_valid_q;
  logic [dllm_pkg::M_DATA_W-1:0] m_data_q;

  logic                  in_fire, out_free, load_out;
  logic [NW-1:0]         in_node;
  logic                  node_ok;
  logic [HW-1:0]         rda, rdb;

  logic                  item_we, use_we, use_wd, nx_we, pv_we;
  logic [HW-1:0]         item_wa, use_wa, nx_wa, pv_wa;
  logic [LW-1:0]         nx_wd, pv_wd;

  logic                  us, have_free;
  logic [LW-1:0]         nxb;

  assign s_axis_tready = (state_q == dllm_pkg::S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign load_out      = ((state_q == dllm_pkg::S_WR2) || (state_q == dllm_pkg::S_DONE)) &&
                         out_free;

  assign in_op   = dllm_pkg::op_e'(s_axis_tuser);
  assign in_node = NW'(s_axis_tdata[dllm_pkg::ITEM_W +: dllm_pkg::NODE_W]);
  assign node_ok = in_node < NW'(NODES);

  // list entry that the operation looks at
  always_comb begin
    case (in_op)
      dllm_pkg::OP_POP_FRONT, dllm_pkg::OP_PEEK_FRONT: tgt_in = head_q;
      dllm_pkg::OP_POP_BACK, dllm_pkg::OP_PEEK_BACK:   tgt_in = tail_q;
      dllm_pkg::OP_INSERT, dllm_pkg::OP_UNLINK:        tgt_in = node_ok ? LW'(in_node) : NIL;
      default:                                         tgt_in = NIL;
    endcase
  end

  assign rda = (tgt_in != NIL) ? tgt_in[HW-1:0] : '0;
  assign rdb = (free_q != NIL) ? free_q[HW-1:0] : '0;

  // entries at or above the fill count were never allocated
  assign us        = us_q && !fresh_a_q;
  assign nxb       = fresh_b_q ? LW'(free_q + 1'b1) : nxb_q;
  assign have_free = (free_q != NIL);

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      nxa_q <= next_mem[rda];
      nxb_q <= next_mem[rdb];
      pv_q  <= prev_mem[rda];
      us_q  <= use_mem[rda];
      it_q  <= item_mem[rda];
    end
    if (item_we) item_mem[item_wa] <= item_q;
    if (use_we)  use_mem[use_wa]   <= use_wd;
    if (nx_we)   next_mem[nx_wa]   <= nx_wd;
    if (pv_we)   prev_mem[pv_wa]   <= pv_wd;
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q      <= in_op;
      item_q    <= ITEM_WIDTH'(s_axis_tdata[dllm_pkg::ITEM_W-1:0]);
      tgt_q     <= tgt_in;
      fresh_a_q <= tgt_in >= fill_q;
      fresh_b_q <= free_q >= fill_q;
    end
    if (state_q == dllm_pkg::S_EXEC) begin
      w2_nx_addr_q <= w2_nx_addr_d;
      w2_nx_data_q <= w2_nx_data_d;
      w2_pv_addr_q <= w2_pv_addr_d;
      w2_pv_data_q <= w2_pv_data_d;
      res_item_q   <= res_item_d;
      res_handle_q <= res_handle_d;
      res_ok_q     <= res_ok_d;
      res_size_q   <= res_size_d;
      res_empty_q  <= res_empty_d;
    end
    if (load_out) begin
      m_data_q <= {{(dllm_pkg::M_DATA_W - dllm_pkg::ITEM_W - dllm_pkg::HANDLE_W
                     - dllm_pkg::SIZE_W - 2){1'b0}},
                   res_empty_q, res_size_q, res_ok_q, res_handle_q, res_item_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= dllm_pkg::S_IDLE;
      head_q     <= NIL;
      tail_q     <= NIL;
      free_q     <= '0;
      cnt_q      <= '0;
      fill_q     <= '0;
      w2_nx_en_q <= 1'b0;
      w2_pv_en_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      free_q     <= free_d;
      cnt_q      <= cnt_d;
      fill_q     <= fill_d;
      w2_nx_en_q <= w2_nx_en_d;
      w2_pv_en_q <= w2_pv_en_d;
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    free_d       = free_q;
    cnt_d        = cnt_q;
    fill_d       = fill_q;
    w2_nx_en_d   = w2_nx_en_q;
    w2_nx_addr_d = w2_nx_addr_q;
    w2_nx_data_d = w2_nx_data_q;
    w2_pv_en_d   = w2_pv_en_q;
    w2_pv_addr_d = w2_pv_addr_q;
    w2_pv_data_d = w2_pv_data_q;
    res_item_d   = '0;
    res_handle_d = '0;
    res_ok_d     = 1'b0;
    item_we      = 1'b0;
    item_wa      = free_q[HW-1:0];
    use_we       = 1'b0;
    use_wa       = free_q[HW-1:0];
    use_wd       = 1'b1;
    nx_we        = 1'b0;
    nx_wa        = free_q[HW-1:0];
    nx_wd        = NIL;
    pv_we        = 1'b0;
    pv_wa        = free_q[HW-1:0];
    pv_wd        = NIL;

    case (state_q)
      dllm_pkg::S_IDLE: begin
        if (in_fire) begin
          state_d = dllm_pkg::S_EXEC;
        end
      end

      dllm_pkg::S_EXEC: begin
        state_d    = dllm_pkg::S_WR2;
        w2_nx_en_d = 1'b0;
        w2_pv_en_d = 1'b0;
        case (op_q)
          dllm_pkg::OP_PUSH_FRONT, dllm_pkg::OP_PUSH_BACK: begin
            if (have_free) begin
              item_we = 1'b1;
              use_we  = 1'b1;
              nx_we   = 1'b1;
              pv_we   = 1'b1;
              free_d  = nxb;
              cnt_d   = LW'(cnt_q + 1'b1);
              if (free_q == fill_q) fill_d = LW'(fill_q + 1'b1);
              res_handle_d = dllm_pkg::HANDLE_W'(free_q);
              res_ok_d     = 1'b1;
              if (op_q == dllm_pkg::OP_PUSH_FRONT) begin
                nx_wd  = head_q;
                head_d = free_q;
                if (head_q != NIL) begin
                  w2_pv_en_d   = 1'b1;
                  w2_pv_addr_d = head_q[HW-1:0];
                  w2_pv_data_d = free_q;
                end else begin
                  tail_d = free_q;
                end
              end else begin
                pv_wd  = tail_q;
                tail_d = free_q;
                if (tail_q != NIL) begin
                  w2_nx_en_d   = 1'b1;
                  w2_nx_addr_d = tail_q[HW-1:0];
                  w2_nx_data_d = free_q;
                end else begin
                  head_d = free_q;
                end
              end
            end
          end

          dllm_pkg::OP_PEEK_FRONT, dllm_pkg::OP_PEEK_BACK: begin
            if ((tgt_q != NIL) && us) begin
              res_item_d = dllm_pkg::ITEM_W'(it_q);
              res_ok_d   = 1'b1;
            end
          end

          dllm_pkg::OP_INSERT: begin
            if ((tgt_q != NIL) && us && have_free) begin
              item_we = 1'b1;
              use_we  = 1'b1;
              nx_we   = 1'b1;
              nx_wd   = nxa_q;
              pv_we   = 1'b1;
              pv_wd   = tgt_q;
              free_d  = nxb;
              cnt_d   = LW'(cnt_q + 1'b1);
              if (free_q == fill_q) fill_d = LW'(fill_q + 1'b1);
              res_handle_d = dllm_pkg::HANDLE_W'(free_q);
              res_ok_d     = 1'b1;
              w2_nx_en_d   = 1'b1;
              w2_nx_addr_d = tgt_q[HW-1:0];
              w2_nx_data_d = free_q;
              if (nxa_q != NIL) begin
                w2_pv_en_d   = 1'b1;
                w2_pv_addr_d = nxa_q[HW-1:0];
                w2_pv_data_d = free_q;
              end else begin
                tail_d = free_q;
              end
            end
          end

          // pop front, pop back and unlink share the unlink path
          default: begin
            if ((tgt_q != NIL) && us) begin
              use_we = 1'b1;
              use_wa = tgt_q[HW-1:0];
              use_wd = 1'b0;
              if (pv_q != NIL) begin
                nx_we = 1'b1;
                nx_wa = pv_q[HW-1:0];
                nx_wd = nxa_q;
              end else begin
                head_d = nxa_q;
              end
              if (nxa_q != NIL) begin
                pv_we = 1'b1;
                pv_wa = nxa_q[HW-1:0];
                pv_wd = pv_q;
              end else begin
                tail_d = pv_q;
              end
              // freed node goes to the head of the free chain
              w2_nx_en_d   = 1'b1;
              w2_nx_addr_d = tgt_q[HW-1:0];
              w2_nx_data_d = free_q;
              free_d       = tgt_q;
              cnt_d        = LW'(cnt_q - 1'b1);
              res_item_d   = dllm_pkg::ITEM_W'(it_q);
              res_ok_d     = 1'b1;
            end
          end
        endcase
      end

      dllm_pkg::S_WR2: begin
        nx_we   = w2_nx_en_q;
        nx_wa   = w2_nx_addr_q;
        nx_wd   = w2_nx_data_q;
        pv_we   = w2_pv_en_q;
        pv_wa   = w2_pv_addr_q;
        pv_wd   = w2_pv_data_q;
        state_d = out_free ? dllm_pkg::S_IDLE : dllm_pkg::S_DONE;
      end

      dllm_pkg::S_DONE: begin
        if (out_free) begin
          state_d = dllm_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = dllm_pkg::S_IDLE;
      end
    endcase
  end

  assign res_size_d  = dllm_pkg::SIZE_W'(cnt_d);
  assign res_empty_d = (cnt_d == '0);

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NIL)
    else $error("node count above pool size");

  a_pool_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_q == NIL) |-> (cnt_q == NIL))
    else $error("free chain empty while list not full");

  a_ends_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((head_q == NIL) == (tail_q == NIL)) && ((head_q == NIL) == (cnt_q == '0)))
    else $error("head, tail and count disagree on empty list");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == dllm_pkg::S_WR2 || state_q == dllm_pkg::S_DONE))
    else $error("result presented outside the write-back states");

endmodule
